FILE: hw/rtl/mcpf_pkg.sv
package mcpf_pkg;

  localparam int TimeW         = 32;
  localparam int PerW          = 31;
  localparam int CntW          = 3;
  localparam int RegW          = 3;
  localparam int DataW         = 32;
  localparam int StepW         = 4;
  localparam int NumPeriodRegs = 4;

  // request opcodes
  localparam logic [1:0] OP_REFRESH = 2'd0;
  localparam logic [1:0] OP_CHECK   = 2'd1;
  localparam logic [1:0] OP_RESET   = 2'd2;

  // configuration register indexes
  localparam logic [RegW-1:0] REG_ACTIVE  = 3'd0;
  localparam logic [RegW-1:0] REG_PERIOD1 = 3'd1;

  typedef logic [3:0]       act_t;
  typedef logic [3:0]       cond_t;
  typedef logic [StepW-1:0] step_t;

  // datapath actions
  localparam act_t ACT_NOP        = 4'd0;
  localparam act_t ACT_LATCH      = 4'd1;
  localparam act_t ACT_CLR_CH     = 4'd2;
  localparam act_t ACT_DIF        = 4'd3;
  localparam act_t ACT_DIV_START  = 4'd4;
  localparam act_t ACT_UPD_REF    = 4'd5;
  localparam act_t ACT_INC_CH     = 4'd6;
  localparam act_t ACT_RESET_ALL  = 4'd7;
  localparam act_t ACT_EMIT_CHECK = 4'd8;
  localparam act_t ACT_EMIT_ZERO  = 4'd9;
  localparam act_t ACT_EMIT_COUNT = 4'd10;

  // jump conditions
  localparam cond_t COND_NEVER       = 4'd0;
  localparam cond_t COND_ALWAYS      = 4'd1;
  localparam cond_t COND_NOT_START   = 4'd2;
  localparam cond_t COND_IS_CHECK    = 4'd3;
  localparam cond_t COND_IS_RESET    = 4'd4;
  localparam cond_t COND_NOT_REFRESH = 4'd5;
  localparam cond_t COND_CH_DONE     = 4'd6;
  localparam cond_t COND_NO_HIT      = 4'd7;
  localparam cond_t COND_DIV_BUSY    = 4'd8;

  // program addresses
  localparam step_t S_IDLE     = 4'd0;
  localparam step_t S_DISPATCH = 4'd1;
  localparam step_t S_LOOP     = 4'd4;
  localparam step_t S_WAIT     = 4'd7;
  localparam step_t S_NEXT     = 4'd9;
  localparam step_t S_RESET    = 4'd10;
  localparam step_t S_CHECK    = 4'd11;
  localparam step_t S_ZERO     = 4'd12;
  localparam step_t S_COUNT    = 4'd13;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic start;
    logic is_check;
    logic is_reset;
    logic is_refresh;
    logic ch_done;
    logic no_hit;
    logic div_busy;
  } stat_t;

  // control store: jump to target when the condition holds, else fall through
  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      4'd0:    w = '{ACT_LATCH,      COND_NOT_START,   S_IDLE};
      4'd1:    w = '{ACT_CLR_CH,     COND_IS_CHECK,    S_CHECK};
      4'd2:    w = '{ACT_NOP,        COND_IS_RESET,    S_RESET};
      4'd3:    w = '{ACT_NOP,        COND_NOT_REFRESH, S_ZERO};
      4'd4:    w = '{ACT_DIF,        COND_CH_DONE,     S_COUNT};
      4'd5:    w = '{ACT_NOP,        COND_NO_HIT,      S_NEXT};
      4'd6:    w = '{ACT_DIV_START,  COND_NEVER,       S_IDLE};
      4'd7:    w = '{ACT_NOP,        COND_DIV_BUSY,    S_WAIT};
      4'd8:    w = '{ACT_UPD_REF,    COND_NEVER,       S_IDLE};
      4'd9:    w = '{ACT_INC_CH,     COND_ALWAYS,      S_LOOP};
      4'd10:   w = '{ACT_RESET_ALL,  COND_ALWAYS,      S_COUNT};
      4'd11:   w = '{ACT_EMIT_CHECK, COND_ALWAYS,      S_IDLE};
      4'd12:   w = '{ACT_EMIT_ZERO,  COND_ALWAYS,      S_IDLE};
      4'd13:   w = '{ACT_EMIT_COUNT, COND_ALWAYS,      S_IDLE};
      default: w = '{ACT_NOP,        COND_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/mcpf_divider.sv
// Restoring remainder unit, one quotient bit per cycle.
module mcpf_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [mcpf_pkg::TimeW-1:0] dividend_i,
  input  logic [mcpf_pkg::PerW-1:0]  divisor_i,
  output logic                      busy_o,
  output logic [mcpf_pkg::PerW-1:0]  rem_o
);

  logic                      busy_q;
  logic [4:0]                cnt_q;
  logic [mcpf_pkg::PerW-1:0]  rem_q;
  logic [mcpf_pkg::PerW-1:0]  dsr_q;
  logic [mcpf_pkg::TimeW-1:0] dvd_q;
  logic [mcpf_pkg::TimeW-1:0] trial;
  logic [mcpf_pkg::TimeW-1:0] diff;
  logic [mcpf_pkg::PerW-1:0]  rem_d;

  assign trial = {rem_q, dvd_q[mcpf_pkg::TimeW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  // remainder stays below the divisor, so it fits PerW bits
  assign rem_d = (trial >= {1'b0, dsr_q}) ? diff[mcpf_pkg::PerW-1:0]
                                          : trial[mcpf_pkg::PerW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd31;
    end else if (busy_q) begin
      if (cnt_q == 5'd0) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dsr_q <= divisor_i;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[mcpf_pkg::TimeW-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

FILE: hw/rtl/mcpf_sequencer.sv
// Step counter over the control store with conditional jumps.
module mcpf_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mcpf_pkg::stat_t        stat_i,
  output mcpf_pkg::act_t         act_o,
  output logic                   busy_o
);

  mcpf_pkg::step_t  step_q;
  mcpf_pkg::step_t  step_d;
  mcpf_pkg::uword_t uw;
  logic             take;

  assign uw = mcpf_pkg::ucode(step_q);

  always_comb begin
    case (uw.cond)
      mcpf_pkg::COND_NEVER:       take = 1'b0;
      mcpf_pkg::COND_ALWAYS:      take = 1'b1;
      mcpf_pkg::COND_NOT_START:   take = !stat_i.start;
      mcpf_pkg::COND_IS_CHECK:    take = stat_i.is_check;
      mcpf_pkg::COND_IS_RESET:    take = stat_i.is_reset;
      mcpf_pkg::COND_NOT_REFRESH: take = !stat_i.is_refresh;
      mcpf_pkg::COND_CH_DONE:     take = stat_i.ch_done;
      mcpf_pkg::COND_NO_HIT:      take = stat_i.no_hit;
      mcpf_pkg::COND_DIV_BUSY:    take = stat_i.div_busy;
      default:                    take = 1'b1;
    endcase
    step_d = take ? uw.target : step_q + mcpf_pkg::step_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mcpf_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign act_o  = uw.act;
  assign busy_o = (step_q != mcpf_pkg::S_IDLE);

endmodule

FILE: hw/rtl/mcpf_datapath.sv
// Channel state, request latch, catch-up arithmetic and result register.
module mcpf_datapath #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  mcpf_pkg::act_t                              act_i,
  input  logic                                        start_i,
  input  logic [1:0]                                  opcode_i,
  input  logic [mcpf_pkg::TimeW-1:0]                  now_time_i,
  input  logic [2:0]                                  channel_index_i,
  input  logic                                        reset_status_i,
  input  logic [mcpf_pkg::CntW-1:0]                   count_i,
  input  logic [NUM_CHANNELS-1:0][mcpf_pkg::PerW-1:0] period_i,
  output mcpf_pkg::stat_t                             stat_o,
  output logic                                        done_o,
  output logic                                        passed_flag_o,
  output logic                                        invalid_index_o,
  output logic [mcpf_pkg::CntW-1:0]                   channel_count_o
);

  logic [1:0]                 op_q;
  logic [mcpf_pkg::TimeW-1:0] now_q;
  logic [2:0]                 idx_q;
  logic                       status_q;
  logic [mcpf_pkg::CntW-1:0]  ch_q;
  logic [mcpf_pkg::TimeW-1:0] dif_q;

  logic [NUM_CHANNELS-1:0][mcpf_pkg::TimeW-1:0] ref_q;
  logic [NUM_CHANNELS-1:0]                      flag_q;

  logic                       done_q;
  logic                       passed_q;
  logic                       inv_q;
  logic [mcpf_pkg::CntW-1:0]  cnt_q;

  logic [mcpf_pkg::TimeW-1:0] ref_sel;
  logic [mcpf_pkg::PerW-1:0]  per_sel;
  logic                       idx_ok;
  logic                       flag_sel;
  logic                       div_busy;
  logic [mcpf_pkg::PerW-1:0]  div_rem;

  always_comb begin
    ref_sel  = '0;
    per_sel  = '0;
    flag_sel = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (ch_q == mcpf_pkg::CntW'(i)) begin
        ref_sel = ref_q[i];
        per_sel = period_i[i];
      end
      if (idx_q == 3'(i + 1)) begin
        flag_sel = flag_q[i];
      end
    end
  end

  assign idx_ok = (idx_q != 3'd0) && (idx_q <= count_i);

  mcpf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (act_i == mcpf_pkg::ACT_DIV_START),
    .dividend_i (dif_q),
    .divisor_i  (per_sel),
    .busy_o     (div_busy),
    .rem_o      (div_rem)
  );

  // request latch, loop pointer and difference register
  always_ff @(posedge clk_i) begin
    if (act_i == mcpf_pkg::ACT_LATCH && start_i) begin
      op_q     <= opcode_i;
      now_q    <= now_time_i;
      idx_q    <= channel_index_i;
      status_q <= reset_status_i;
    end
    if (act_i == mcpf_pkg::ACT_DIF) begin
      dif_q <= now_q - ref_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= '0;
    end else if (act_i == mcpf_pkg::ACT_CLR_CH) begin
      ch_q <= '0;
    end else if (act_i == mcpf_pkg::ACT_INC_CH) begin
      ch_q <= ch_q + mcpf_pkg::CntW'(1);
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q  <= '0;
      flag_q <= '0;
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        case (act_i)
          mcpf_pkg::ACT_UPD_REF: begin
            if (ch_q == mcpf_pkg::CntW'(i)) begin
              ref_q[i]  <= now_q - {1'b0, div_rem};
              flag_q[i] <= 1'b1;
            end
          end
          mcpf_pkg::ACT_RESET_ALL: begin
            if (mcpf_pkg::CntW'(i) < count_i) begin
              ref_q[i]  <= now_q;
              flag_q[i] <= status_q;
            end
          end
          mcpf_pkg::ACT_EMIT_CHECK: begin
            if (idx_ok && idx_q == 3'(i + 1)) begin
              flag_q[i] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // result register, shown for one cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      passed_q <= 1'b0;
      inv_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= (act_i == mcpf_pkg::ACT_EMIT_CHECK) ||
                (act_i == mcpf_pkg::ACT_EMIT_ZERO)  ||
                (act_i == mcpf_pkg::ACT_EMIT_COUNT);
      case (act_i)
        mcpf_pkg::ACT_EMIT_CHECK: begin
          passed_q <= idx_ok & flag_sel;
          inv_q    <= !idx_ok;
          cnt_q    <= '0;
        end
        mcpf_pkg::ACT_EMIT_ZERO: begin
          passed_q <= 1'b0;
          inv_q    <= 1'b0;
          cnt_q    <= '0;
        end
        mcpf_pkg::ACT_EMIT_COUNT: begin
          passed_q <= 1'b0;
          inv_q    <= 1'b0;
          cnt_q    <= count_i;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.start      = start_i;
  assign stat_o.is_check   = (op_q == mcpf_pkg::OP_CHECK);
  assign stat_o.is_reset   = (op_q == mcpf_pkg::OP_RESET);
  assign stat_o.is_refresh = (op_q == mcpf_pkg::OP_REFRESH);
  assign stat_o.ch_done    = (ch_q >= count_i);
  assign stat_o.no_hit     = (per_sel == '0) || (dif_q < {1'b0, per_sel});
  assign stat_o.div_busy   = div_busy;

  assign done_o          = done_q;
  assign passed_flag_o   = passed_q;
  assign invalid_index_o = inv_q;
  assign channel_count_o = cnt_q;

endmodule

FILE: hw/rtl/multi_channel_period_flagger.sv
// Multi-channel period flagger. A request is taken when start is high and
// busy is low; its single result appears for exactly one cycle with done_o
// high, and the receiver cannot hold it off, so it must sample every strobe.
// A check, a reset-all or an unused opcode goes straight to its result; a
// refresh visits each active channel in turn, and for each channel that is
// due the catch-up remainder (time since reference modulo period) comes from
// a shared restoring divider that yields one bit a cycle. A period of 0
// disables its channel; the active count is clamped to NUM_CHANNELS.
// Configuration writes are taken only while idle with no request offered
// (cfg_ready_o low while busy or start is high). No clearing pass is needed
// after reset: reference times and flags reset to zero at once.
module multi_channel_period_flagger #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [mcpf_pkg::TimeW-1:0]    now_time_i,
  input  logic [2:0]                    channel_index_i,
  input  logic                          reset_status_i,
  // result channel
  output logic                          done_o,
  output logic                          passed_flag_o,
  output logic                          invalid_index_o,
  output logic [mcpf_pkg::CntW-1:0]     channel_count_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcpf_pkg::RegW-1:0]     cfg_index_i,
  input  logic [mcpf_pkg::DataW-1:0]    cfg_data_i
);

  logic [mcpf_pkg::CntW-1:0]                   active_q;
  logic [NUM_CHANNELS-1:0][mcpf_pkg::PerW-1:0] period_q;
  logic [mcpf_pkg::CntW-1:0]                   live_count;
  logic                                        cfg_we;
  logic                                        seq_busy;
  mcpf_pkg::act_t                              act;
  mcpf_pkg::stat_t                             stat;

  // a request offered at the same edge goes first, so the write waits
  assign cfg_ready_o = !seq_busy && !start;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cfg_we && cfg_index_i == mcpf_pkg::REG_ACTIVE) begin
      active_q <= cfg_data_i[mcpf_pkg::CntW-1:0];
    end
  end

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_period
    if (g < mcpf_pkg::NumPeriodRegs) begin : g_reg
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          period_q[g] <= '0;
        end else if (cfg_we &&
                     cfg_index_i == mcpf_pkg::REG_PERIOD1 + mcpf_pkg::RegW'(g)) begin
          period_q[g] <= cfg_data_i[mcpf_pkg::PerW-1:0];
        end
      end
    end else begin : g_none
      // channels beyond the register list never have a period
      assign period_q[g] = '0;
    end
  end

  // a count above the channel total acts as the total
  assign live_count = (active_q > mcpf_pkg::CntW'(NUM_CHANNELS))
                    ? mcpf_pkg::CntW'(NUM_CHANNELS) : active_q;

  mcpf_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .act_o  (act),
    .busy_o (seq_busy)
  );

  mcpf_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .act_i           (act),
    .start_i         (start),
    .opcode_i        (opcode_i),
    .now_time_i      (now_time_i),
    .channel_index_i (channel_index_i),
    .reset_status_i  (reset_status_i),
    .count_i         (live_count),
    .period_i        (period_q),
    .stat_o          (stat),
    .done_o          (done_o),
    .passed_flag_o   (passed_flag_o),
    .invalid_index_o (invalid_index_o),
    .channel_count_o (channel_count_o)
  );

  assign busy = seq_busy;

  // a result only follows a request in progress
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result strobe without request in progress");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start");

  // an invalid check reports neither a flag nor a count
  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && invalid_index_o) |-> (!passed_flag_o && channel_count_o == '0))
    else $error("invalid check result carries data");

  // the reported count never exceeds the channel total
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (channel_count_o <= mcpf_pkg::CntW'(NUM_CHANNELS)))
    else $error("channel count out of range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

// Testbench for multi_channel_period_flagger.
// A queue of pending jobs (requests, register writes and settle points) is
// filled up front. A clocked driver works through it and predicts each
// request's result when the request is taken. A clocked monitor checks every
// done_o strobe against the oldest prediction.
module tb;

  localparam int          NCH         = 4;
  localparam int          CLK_HALF    = 6;
  localparam int          RESET_LEN   = 11;
  localparam int          DRAIN_TAIL  = 170;      // a little over the worst refresh
  localparam int          RANDOM_REQS = 900;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  // opcode 3 is not decoded by the block
  localparam logic [1:0]                OP_UNUSED      = 2'd3;
  // first register index past the period registers, writes there are dropped
  localparam logic [mcpf_pkg::RegW-1:0] REG_FIRST_DEAD =
    mcpf_pkg::REG_PERIOD1 + mcpf_pkg::RegW'(mcpf_pkg::NumPeriodRegs);

  typedef enum logic [1:0] {JOB_REQUEST, JOB_REG_WRITE, JOB_SETTLE} job_kind_e;

  typedef struct {
    job_kind_e                 kind;
    logic [1:0]                op;
    logic [31:0]               now;
    logic [2:0]                idx;
    logic                      status;
    logic [mcpf_pkg::RegW-1:0] reg_idx;
    logic [31:0]               reg_data;
    int unsigned               gap;          // idle cycles once this job is done
  } job_t;

  typedef struct packed {
    logic                      passed;
    logic                      invalid;
    logic [mcpf_pkg::CntW-1:0] count;
  } verdict_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       start           = 1'b0;
  logic [1:0]                 opcode_i        = '0;
  logic [mcpf_pkg::TimeW-1:0] now_time_i      = '0;
  logic [2:0]                 channel_index_i = '0;
  logic                       reset_status_i  = 1'b0;
  logic                       cfg_valid_i     = 1'b0;
  logic [mcpf_pkg::RegW-1:0]  cfg_index_i     = '0;
  logic [mcpf_pkg::DataW-1:0] cfg_data_i      = '0;
  logic                       busy;
  logic                       done_o;
  logic                       passed_flag_o;
  logic                       invalid_index_o;
  logic [mcpf_pkg::CntW-1:0]  channel_count_o;
  logic                       cfg_ready_o;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  multi_channel_period_flagger #(
    .NUM_CHANNELS(NCH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .now_time_i     (now_time_i),
    .channel_index_i(channel_index_i),
    .reset_status_i (reset_status_i),
    .done_o         (done_o),
    .passed_flag_o  (passed_flag_o),
    .invalid_index_o(invalid_index_o),
    .channel_count_o(channel_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Predictor: a shadow of the block's registers and channel state
  // ---------------------------------------------------------------------------
  logic [2:0]                 shadow_active = '0;
  logic [mcpf_pkg::PerW-1:0]  shadow_period [NCH];
  logic [mcpf_pkg::TimeW-1:0] shadow_ref    [NCH];
  logic                       shadow_flag   [NCH];

  initial begin
    for (int c = 0; c < NCH; c++) begin
      shadow_period[c] = '0;
      shadow_ref[c]    = '0;
      shadow_flag[c]   = 1'b0;
    end
  end

  function automatic int unsigned live_channels();
    return (shadow_active > NCH) ? NCH : shadow_active;
  endfunction

  function automatic void shadow_reg_write(input logic [mcpf_pkg::RegW-1:0] idx,
                                           input logic [31:0] data);
    int unsigned ch;
    if (idx == mcpf_pkg::REG_ACTIVE) begin
      shadow_active = data[2:0];
    end else if (idx >= mcpf_pkg::REG_PERIOD1 && idx < REG_FIRST_DEAD) begin
      ch = 32'(idx - mcpf_pkg::REG_PERIOD1);
      if (ch < NCH) shadow_period[ch] = data[mcpf_pkg::PerW-1:0];
    end
  endfunction

  // Apply one request to the shadow state and return the result it must give.
  function automatic verdict_t flagger_step(input job_t j);
    verdict_t    v;
    int unsigned live;
    logic [31:0] lag;
    logic [31:0] per;
    v    = '0;
    live = live_channels();
    case (j.op)
      mcpf_pkg::OP_REFRESH: begin
        for (int c = 0; c < live; c++) begin
          per = {1'b0, shadow_period[c]};
          lag = j.now - shadow_ref[c];
          // due: snap the reference to the latest whole period not past now
          if (per != '0 && lag >= per) begin
            shadow_ref[c]  = j.now - (lag % per);
            shadow_flag[c] = 1'b1;
          end
        end
        v.count = mcpf_pkg::CntW'(live);
      end
      mcpf_pkg::OP_CHECK: begin
        if (j.idx >= 1 && j.idx <= live) begin
          v.passed              = shadow_flag[j.idx - 1];
          shadow_flag[j.idx - 1] = 1'b0;
        end else begin
          v.invalid = 1'b1;
        end
      end
      mcpf_pkg::OP_RESET: begin
        for (int c = 0; c < live; c++) begin
          shadow_ref[c]  = j.now;
          shadow_flag[c] = j.status;
        end
        v.count = mcpf_pkg::CntW'(live);
      end
      default: ;                           // unused opcode: all zero
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Job queue and stimulus helpers
  // ---------------------------------------------------------------------------
  job_t     job_q[$];
  verdict_t verdicts_due[$];

  int unsigned n_refresh, n_check, n_reset, n_unused, n_reg_writes;
  int unsigned n_results, n_flags_set, n_invalid, n_errors;

  // mostly back to back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic void push_request(input logic [1:0] op, input logic [31:0] now,
                                       input logic [2:0] idx, input logic status,
                                       input int unsigned gap);
    job_t j;
    j         = '{kind: JOB_REQUEST, default: '0};
    j.op      = op;
    j.now     = now;
    j.idx     = idx;
    j.status  = status;
    j.gap     = gap;
    job_q.push_back(j);
  endfunction

  function automatic void push_reg(input logic [mcpf_pkg::RegW-1:0] idx,
                                   input logic [31:0] data);
    job_t j;
    j          = '{kind: JOB_REG_WRITE, default: '0};
    j.reg_idx  = idx;
    j.reg_data = data;
    job_q.push_back(j);
  endfunction

  // wait for every outstanding result, then hold off for gap cycles
  function automatic void push_settle(input int unsigned gap);
    job_t j;
    j      = '{kind: JOB_SETTLE, default: '0};
    j.gap  = gap;
    job_q.push_back(j);
  endfunction

  // period register data: junk in bit 31, value biased to small periods
  function automatic logic [31:0] pick_period_data();
    int unsigned r;
    logic [30:0] p;
    r = $urandom_range(0, 99);
    if      (r < 10) p = '0;
    else if (r < 15) p = 31'd1;
    else if (r < 60) p = 31'($urandom_range(2, 40));
    else if (r < 80) p = 31'($urandom_range(41, 5000));
    else if (r < 93) p = 31'($urandom);
    else             p = '1;
    return {1'($urandom), p};
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: works the job queue, predicts at request acceptance
  // ---------------------------------------------------------------------------
  int unsigned idle_left = 0;

  always @(posedge clk_i) begin : driver
    job_t j;
    logic hold_req, hold_cfg, quiet, nxt_start, nxt_cfg;
    if (rst_ni) begin
      if (start && !busy) begin
        verdicts_due.push_back(flagger_step('{kind: JOB_REQUEST, op: opcode_i,
                                              now: now_time_i, idx: channel_index_i,
                                              status: reset_status_i, reg_idx: '0,
                                              reg_data: '0, gap: 0}));
        case (opcode_i)
          mcpf_pkg::OP_REFRESH: n_refresh++;
          mcpf_pkg::OP_CHECK:   n_check++;
          mcpf_pkg::OP_RESET:   n_reset++;
          default:              n_unused++;
        endcase
      end
      if (cfg_valid_i && cfg_ready_o) begin
        shadow_reg_write(cfg_index_i, cfg_data_i);
        n_reg_writes++;
      end
      hold_req  = start && busy;
      hold_cfg  = cfg_valid_i && !cfg_ready_o;
      // nothing in flight and no strobe being taken at this very edge
      quiet     = verdicts_due.size() == 0 && !done_o;
      nxt_start = hold_req;
      nxt_cfg   = hold_cfg;
      if (!hold_req && !hold_cfg) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (job_q.size() > 0) begin
          j = job_q[0];
          case (j.kind)
            JOB_REQUEST: begin
              void'(job_q.pop_front());
              opcode_i        <= j.op;
              now_time_i      <= j.now;
              channel_index_i <= j.idx;
              reset_status_i  <= j.status;
              nxt_start        = 1'b1;
              idle_left        = j.gap;
            end
            JOB_REG_WRITE: begin
              if (quiet) begin
                void'(job_q.pop_front());
                cfg_index_i <= j.reg_idx;
                cfg_data_i  <= j.reg_data;
                nxt_cfg      = 1'b1;
              end
            end
            default: begin
              if (quiet) begin
                void'(job_q.pop_front());
                idle_left = j.gap;
              end
            end
          endcase
        end
      end
      start       <= nxt_start;
      cfg_valid_i <= nxt_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobe is a result, the receiver cannot refuse it
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    verdict_t got, want;
    if (rst_ni && done_o) begin
      got = '{passed: passed_flag_o, invalid: invalid_index_o, count: channel_count_o};
      if (verdicts_due.size() == 0) begin
        $display("%t: unexpected result passed=%b invalid=%b count=%0d",
                 $time, got.passed, got.invalid, got.count);
        n_errors++;
      end else begin
        want = verdicts_due.pop_front();
        if (got !== want) begin
          $display("%t: result %0d mismatch: expected passed=%b invalid=%b count=%0d,",
                   $time, n_results, want.passed, want.invalid, want.count);
          $display("%t:   actual passed=%b invalid=%b count=%0d",
                   $time, got.passed, got.invalid, got.count);
          n_errors++;
        end
        n_results++;
        if (got.passed)  n_flags_set++;
        if (got.invalid) n_invalid++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%t: timed out after %0d cycles", $time, cycle_count);
      $display("multi_channel_period_flagger regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] wall;
    int unsigned n_random, phase_len, live, r;
    logic        burst;
    logic [2:0]  act;
    logic [1:0]  op;

    // directed: registers still at reset, nothing active
    push_request(mcpf_pkg::OP_CHECK,   32'h0,         3'd1, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_REFRESH, 32'h0,         3'd0, 1'b0, pick_gap());
    push_request(OP_UNUSED,            32'hFFFF_FFFF, 3'd7, 1'b1, pick_gap());
    push_request(mcpf_pkg::OP_RESET,   32'h0,         3'd0, 1'b1, pick_gap());
    // count above the channel limit clamps; bit 31 of a period is dropped;
    // one channel disabled; writes past the period registers are dropped
    push_reg(mcpf_pkg::REG_ACTIVE,  32'hFFFF_FFFF);
    push_reg(mcpf_pkg::REG_PERIOD1, 32'h8000_0001);
    push_reg(mcpf_pkg::REG_PERIOD1 + mcpf_pkg::RegW'(1), 32'h7FFF_FFFF);
    push_reg(mcpf_pkg::REG_PERIOD1 + mcpf_pkg::RegW'(2), 32'h0);
    push_reg(mcpf_pkg::REG_PERIOD1 + mcpf_pkg::RegW'(3), 32'd10);
    for (int k = REG_FIRST_DEAD; k < (1 << mcpf_pkg::RegW); k++) begin
      push_reg(mcpf_pkg::RegW'(k), $urandom);
    end
    // references near the top, then a refresh that wraps past zero
    push_request(mcpf_pkg::OP_RESET,   32'hFFFF_FFF0, 3'd0, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_REFRESH, 32'h0000_0005, 3'd0, 1'b0, pick_gap());
    for (int k = 1; k <= NCH; k++) begin
      push_request(mcpf_pkg::OP_CHECK, 32'h0, 3'(k), 1'b0, pick_gap());
    end
    push_request(mcpf_pkg::OP_CHECK,   32'h0, 3'd0, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'h0, 3'd5, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'h0, 3'd7, 1'b0, pick_gap());
    // the largest period falls due exactly
    push_request(mcpf_pkg::OP_REFRESH, 32'h7FFF_FFEF, 3'd0, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'h0,         3'd2, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_REFRESH, 32'hFFFF_FFFF, 3'd0, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_RESET,   32'h0,         3'd0, 1'b1, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'h0,         3'd3, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'h0,         3'd3, 1'b0, pick_gap());
    // shrink the count: upper channels keep their state while inactive
    push_reg(mcpf_pkg::REG_ACTIVE, 32'd2);
    push_request(mcpf_pkg::OP_REFRESH, 32'd100, 3'd0, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'd0,   3'd3, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_RESET,   32'd123, 3'd0, 1'b0, pick_gap());
    push_reg(mcpf_pkg::REG_ACTIVE, 32'd4);
    push_request(mcpf_pkg::OP_CHECK,   32'd0,   3'd4, 1'b0, pick_gap());
    push_request(mcpf_pkg::OP_CHECK,   32'd0,   3'd1, 1'b0, pick_gap());

    // random phases: settle, rewrite every register, then a run of requests
    wall     = $urandom;
    n_random = 0;
    while (n_random < RANDOM_REQS) begin
      push_settle($urandom_range(0, 30));
      r = $urandom_range(0, 99);
      if      (r < 70) act = 3'($urandom_range(1, NCH));
      else if (r < 80) act = 3'(NCH);
      else if (r < 90) act = 3'd0;
      else             act = 3'($urandom_range(NCH + 1, 7));
      live = (act > NCH) ? NCH : act;
      push_reg(mcpf_pkg::REG_ACTIVE, {29'($urandom), act});
      for (int k = 0; k < mcpf_pkg::NumPeriodRegs; k++) begin
        push_reg(mcpf_pkg::REG_PERIOD1 + mcpf_pkg::RegW'(k), pick_period_data());
      end
      if ($urandom_range(0, 3) == 0) begin
        push_reg(mcpf_pkg::RegW'($urandom_range(REG_FIRST_DEAD, 7)), $urandom);
      end
      // now and then park the clock just below the wrap
      if ($urandom_range(0, 3) == 0) wall = 32'hFFFF_FFFF - $urandom_range(0, 300);

      burst     = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 110);
      if ($urandom_range(0, 1)) begin
        push_request(mcpf_pkg::OP_RESET, wall, 3'($urandom), 1'($urandom),
                     burst ? 0 : pick_gap());
        n_random++;
      end
      for (int k = 0; k < phase_len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          // time moves on: mostly a few periods, sometimes far
          r = $urandom_range(0, 99);
          if      (r < 70) wall += $urandom_range(0, 80);
          else if (r < 90) wall += $urandom_range(81, 5000);
          else if (r < 98) wall += $urandom;
          push_request(mcpf_pkg::OP_REFRESH, wall, 3'($urandom), 1'($urandom),
                       burst ? 0 : pick_gap());
        end else if (r < 85) begin
          push_request(mcpf_pkg::OP_CHECK, $urandom,
                       (live > 0) ? 3'($urandom_range(1, live)) : 3'($urandom),
                       1'($urandom), burst ? 0 : pick_gap());
        end else if (r < 90) begin
          push_request(mcpf_pkg::OP_RESET, wall, 3'($urandom), 1'($urandom),
                       burst ? 0 : pick_gap());
        end else if (r < 95) begin
          push_request(mcpf_pkg::OP_CHECK, $urandom, 3'($urandom), 1'($urandom),
                       burst ? 0 : pick_gap());
        end else begin
          // noise: unused opcode or a refresh at an arbitrary time
          op = $urandom_range(0, 1) ? OP_UNUSED : mcpf_pkg::OP_REFRESH;
          push_request(op, $urandom, 3'($urandom), 1'($urandom), burst ? 0 : pick_gap());
        end
        n_random++;
        if ($urandom_range(0, 49) == 0) push_settle($urandom_range(0, 40));
      end
    end

    repeat (RESET_LEN) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (job_q.size() > 0 || start || cfg_valid_i || verdicts_due.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);

    $display("Covered %0d refresh, %0d check, %0d reset-all and %0d unused-opcode requests"
             , n_refresh, n_check, n_reset, n_unused);
    $display("over %0d register writes; %0d results seen, %0d flags read set, %0d bad indexes"
             , n_reg_writes, n_results, n_flags_set, n_invalid);
    if (verdicts_due.size() > 0) begin
      $display("%t: %0d results never arrived", $time, verdicts_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("multi_channel_period_flagger regression: pass");
    end else begin
      $display("multi_channel_period_flagger regression: fail");
    end
    $finish;
  end

endmodule
